FILE: rtl/qexp_pkg.sv
package qexp_pkg;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [11:0]        angle;
      logic [15:0]        life_left;
      logic [15:0]        life_total;
      logic [15:0]        size_begin;
      logic [15:0]        size_final;
      logic [31:0]        color_begin;
      logic [31:0]        color_final;
      logic [15:0]        noise_seed;
      logic [15:0]        pipe_key;
   } req_type;

   typedef struct packed {
      logic signed [23:0] vert_x;
      logic signed [23:0] vert_y;
      logic               tex_u;
      logic               tex_v;
      logic [31:0]        vert_color;
      logic [15:0]        progress;
      logic [15:0]        seed_out;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      CORNER_TL,
      CORNER_TR,
      CORNER_BL,
      CORNER_BR
   } corner_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
   } point_type;

   // One finished quad: corner positions indexed by corner_type.
   typedef struct packed {
      point_type [3:0] corner;
      logic [31:0]     color;
      logic [15:0]     progress;
      logic [15:0]     seed;
   } quad_type;

   localparam int DIV_STAGES = 4;
   localparam int DIV_STEPS  = 4;

   localparam logic [15:0] SIN_A = 16'd51472;
   localparam logic [15:0] SIN_B = 16'd21024;
   localparam logic [15:0] SIN_C = 16'd2320;

   localparam logic [2:0] VERT_LAST = 3'd5;

   // Emission order of the two triangles: tl, tr, bl, tr, br, bl.
   function automatic corner_type corner_of(input logic [2:0] k);
      corner_type c;
      case (k)
         3'd0: c = CORNER_TL;
         3'd1: c = CORNER_TR;
         3'd2: c = CORNER_BL;
         3'd3: c = CORNER_TR;
         3'd4: c = CORNER_BR;
         3'd5: c = CORNER_BL;
         default: c = CORNER_TL;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/qexp_div.sv
module qexp_div (
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic [15:0] quotient
);
   import qexp_pkg::*;

   // Fractional restoring division: the remainder starts at the dividend,
   // which is below the divisor whenever the quotient is used.
   logic [16:0] rem_ff [DIV_STAGES];
   logic [15:0] quo_ff [DIV_STAGES];
   logic [15:0] dsr_ff [DIV_STAGES];
   logic [16:0] rem_in [DIV_STAGES];
   logic [15:0] quo_in [DIV_STAGES];
   logic [15:0] dsr_in [DIV_STAGES];

   always_comb begin
      logic [16:0] r;
      logic [15:0] q;
      logic [15:0] d;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            r = {1'b0, dividend};
            q = '0;
            d = divisor;
         end else begin
            r = rem_ff[s-1];
            q = quo_ff[s-1];
            d = dsr_ff[s-1];
         end
         for (int j = 0; j < DIV_STEPS; j++) begin
            r = {r[15:0], 1'b0};
            if (r >= {1'b0, d}) begin
               r = r - {1'b0, d};
               q = {q[14:0], 1'b1};
            end else begin
               q = {q[14:0], 1'b0};
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
         dsr_in[s] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            dsr_ff[s] <= dsr_in[s];
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

FILE: rtl/qexp_sin.sv
module qexp_sin (
   input  logic               clock,
   input  logic               enable,
   input  logic [15:0]        phase,
   output logic signed [17:0] value
);
   import qexp_pkg::*;

   // Quarter-wave odd polynomial, one multiply per stage, Q15 result.
   logic [16:0] z1_ff, z2_ff, z3_ff;
   logic [16:0] zz1_ff, zz2_ff;
   logic [15:0] r2_ff, r3_ff;
   logic [16:0] v4_ff;
   logic        neg1_ff, neg2_ff, neg3_ff, neg4_ff;

   logic [16:0] z_raw, z1_in, zz1_in;
   logic [33:0] prod1;
   logic [28:0] prod2;
   logic [15:0] r2_in;
   logic [32:0] prod3;
   logic [15:0] r3_in;
   logic [32:0] prod4;
   logic [16:0] v4_in;

   always_comb begin
      z_raw  = {2'b00, phase[13:0], 1'b0};
      z1_in  = phase[14] ? (17'd32768 - z_raw) : z_raw;
      prod1  = 34'(z1_in) * 34'(z1_in);
      zz1_in = prod1[31:15];
      prod2  = 29'(SIN_C) * 29'(zz1_ff);
      r2_in  = SIN_B - {2'b00, prod2[28:15]};
      prod3  = 33'(r2_ff) * 33'(zz2_ff);
      r3_in  = SIN_A - prod3[30:15];
      prod4  = 33'(r3_ff) * 33'(z3_ff);
      v4_in  = prod4[31:15];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z1_ff   <= z1_in;
         zz1_ff  <= zz1_in;
         neg1_ff <= phase[15];
         z2_ff   <= z1_ff;
         zz2_ff  <= zz1_ff;
         r2_ff   <= r2_in;
         neg2_ff <= neg1_ff;
         z3_ff   <= z2_ff;
         r3_ff   <= r3_in;
         neg3_ff <= neg2_ff;
         v4_ff   <= v4_in;
         neg4_ff <= neg3_ff;
      end
   end

   assign value = neg4_ff ? -$signed({1'b0, v4_ff}) : $signed({1'b0, v4_ff});

endmodule

FILE: rtl/qexp_out.sv
module qexp_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               quad_valid,
   input  qexp_pkg::quad_type quad,
   output logic               quad_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output qexp_pkg::rsp_type  rsp_data
);
   import qexp_pkg::*;

   logic [2:0] k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load;
   corner_type corner;
   point_type  pt;

   always_comb begin
      load         = quad_valid && (!rsp_valid_ff || rsp_ready);
      quad_take    = load && (k_ff == VERT_LAST);
      corner       = corner_of(k_ff);
      pt           = quad.corner[corner];
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         k_in                   = (k_ff == VERT_LAST) ? 3'd0 : k_ff + 3'd1;
         rsp_valid_in           = 1'b1;
         rsp_data_in.vert_x     = pt.x;
         rsp_data_in.vert_y     = pt.y;
         rsp_data_in.tex_u      = (corner == CORNER_TR) || (corner == CORNER_BR);
         rsp_data_in.tex_v      = (corner == CORNER_BL) || (corner == CORNER_BR);
         rsp_data_in.vert_color = quad.color;
         rsp_data_in.progress   = quad.progress;
         rsp_data_in.seed_out   = quad.seed;
         rsp_data_in.last       = (k_ff == VERT_LAST);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_take_wraps: assert property (@(posedge clock) disable iff (reset)
      quad_take |=> (k_ff == 3'd0))
      else $error("vertex counter did not wrap after the sixth vertex");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= VERT_LAST)
      else $error("vertex counter out of range");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last |-> !rsp_data_ff.tex_u && rsp_data_ff.tex_v)
      else $error("last vertex is not the bottom-left corner");

endmodule

FILE: rtl/particle_quad_expander_core.sv
// Particle quad expander: each accepted particle record that is alive and whose
// pipe_key matches the draw_key register becomes six vertex transfers on the
// response channel (tl, tr, bl, tr, br, bl), the sixth flagged with last.
// Dead or foreign-key particles are accepted and produce nothing. The datapath
// is an eight-stage pipeline: four stages of a radix-2 divider for progress
// run beside four stages of the sine/cosine polynomial, then blend, rotate,
// round and offset stages. The single response register sends one vertex per
// cycle while rsp_ready is high, and a drawn particle holds the last stage
// until its sixth vertex is taken; skipped particles are accepted one per
// cycle while the pipeline advances. draw_key should only be written while
// the block holds no particle.
module particle_quad_expander_core #(
   parameter int ANGLE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qexp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qexp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [15:0]       csr_write_data
);
   import qexp_pkg::*;

   // Fields that ride alongside the divider and sine stages.
   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        size_begin;
      logic [15:0]        size_final;
      logic [31:0]        color_begin;
      logic [31:0]        color_final;
      logic [15:0]        seed;
      logic               sat;
   } side_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [31:0]        color;
      logic [15:0]        prog;
      logic [15:0]        seed;
      logic [15:0]        size;
      logic signed [17:0] sin;
      logic signed [17:0] cos;
   } blend_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [31:0]        color;
      logic [15:0]        prog;
      logic [15:0]        seed;
      logic signed [37:0] hc;
      logic signed [37:0] hs;
   } rot_type;

   // Rounded offsets: p = hc + hs, m = hc - hs, and their negations.
   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [31:0]        color;
      logic [15:0]        prog;
      logic [15:0]        seed;
      logic [23:0]        r_p;
      logic [23:0]        r_np;
      logic [23:0]        r_m;
      logic [23:0]        r_nm;
   } ofs_type;

   logic [15:0] draw_key_ff;
   logic [7:0]  vld_ff, vld_in;
   side_type    side_ff [DIV_STAGES];
   side_type    side_in;
   blend_type   st5_ff, st5_in;
   rot_type     st6_ff, st6_in;
   ofs_type     st7_ff, st7_in;
   quad_type    quad_ff, quad_in;

   logic        adv;
   logic        quad_take;
   logic [15:0] quotient;
   logic [15:0] phase;
   logic [15:0] phase_cos;
   logic signed [17:0] sin_val, cos_val;

   // The whole pipeline moves together; it stalls only when the last stage
   // still holds a quad whose six vertices have not all been sent.
   assign adv       = !vld_ff[7] || quad_take;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_key_ff <= '0;
      end else if (csr_write_en) begin
         draw_key_ff <= csr_write_data;
      end
   end

   // Angle masked to ANGLE_BITS and scaled to a 16-bit turn.
   assign phase     = 16'((32'(req_data.angle) & ((32'd1 << ANGLE_BITS) - 32'd1))
                          << (16 - ANGLE_BITS));
   assign phase_cos = phase + 16'h4000;

   qexp_div u_div (
      .clock    (clock),
      .enable   (adv),
      .dividend (req_data.life_left),
      .divisor  (req_data.life_total),
      .quotient (quotient)
   );

   qexp_sin u_sin (
      .clock  (clock),
      .enable (adv),
      .phase  (phase),
      .value  (sin_val)
   );

   qexp_sin u_cos (
      .clock  (clock),
      .enable (adv),
      .phase  (phase_cos),
      .value  (cos_val)
   );

   function automatic logic [7:0] blend8(input logic [7:0] f, input logic [7:0] b,
                                         input logic [16:0] w, input logic [16:0] wn);
      logic [25:0] sum;
      sum = 26'(f) * 26'(wn) + 26'(b) * 26'(w);
      return sum[23:16];
   endfunction

   always_comb begin
      logic [15:0] prog;
      logic [16:0] w, wn;
      logic [33:0] size_sum;
      logic signed [19:0] h;
      logic signed [38:0] hc, hs;
      logic signed [38:0] sp, snp, sm, snm;
      side_type s4;

      // Entry: drop dead and foreign-key particles right here.
      vld_in[0] = req_valid && (req_data.life_left != 16'd0)
                  && (req_data.pipe_key == draw_key_ff);
      for (int i = 1; i < 8; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
      side_in.pos_x       = req_data.pos_x;
      side_in.pos_y       = req_data.pos_y;
      side_in.size_begin  = req_data.size_begin;
      side_in.size_final  = req_data.size_final;
      side_in.color_begin = req_data.color_begin;
      side_in.color_final = req_data.color_final;
      side_in.seed        = req_data.noise_seed;
      side_in.sat         = req_data.life_left >= req_data.life_total;

      // Blend stage. The weight reaches 65536 at full progress so that a
      // saturated particle shows exactly its begin values.
      s4   = side_ff[DIV_STAGES-1];
      prog = s4.sat ? 16'hFFFF : quotient;
      w    = {1'b0, prog} + 17'(prog[15]);
      wn   = 17'h10000 - w;
      for (int ch = 0; ch < 4; ch++) begin
         st5_in.color[ch*8 +: 8] = blend8(s4.color_final[ch*8 +: 8],
                                          s4.color_begin[ch*8 +: 8], w, wn);
      end
      size_sum     = 34'(s4.size_final) * 34'(wn) + 34'(s4.size_begin) * 34'(w);
      st5_in.size  = size_sum[31:16];
      st5_in.prog  = prog;
      st5_in.pos_x = s4.pos_x;
      st5_in.pos_y = s4.pos_y;
      st5_in.seed  = s4.seed;
      st5_in.sin   = sin_val;
      st5_in.cos   = cos_val;

      // Rotate stage: half size in Q.8 is the Q12.4 size times eight.
      h            = $signed({1'b0, st5_ff.size, 3'b000});
      st6_in.hc    = h * st5_ff.cos;
      st6_in.hs    = h * st5_ff.sin;
      st6_in.pos_x = st5_ff.pos_x;
      st6_in.pos_y = st5_ff.pos_y;
      st6_in.color = st5_ff.color;
      st6_in.prog  = st5_ff.prog;
      st6_in.seed  = st5_ff.seed;

      // Round stage: adding half and shifting rounds halves toward plus
      // infinity; only the low 24 bits matter since the position wraps.
      hc  = {st6_ff.hc[37], st6_ff.hc};
      hs  = {st6_ff.hs[37], st6_ff.hs};
      sp  = hc + hs + 39'sd16384;
      snp = 39'sd16384 - hc - hs;
      sm  = hc - hs + 39'sd16384;
      snm = hs - hc + 39'sd16384;
      st7_in.r_p   = sp[38:15];
      st7_in.r_np  = snp[38:15];
      st7_in.r_m   = sm[38:15];
      st7_in.r_nm  = snm[38:15];
      st7_in.pos_x = st6_ff.pos_x;
      st7_in.pos_y = st6_ff.pos_y;
      st7_in.color = st6_ff.color;
      st7_in.prog  = st6_ff.prog;
      st7_in.seed  = st6_ff.seed;

      // Offset stage: place the four corners around the particle center.
      quad_in.corner[CORNER_TL].x = st7_ff.pos_x + $signed(st7_ff.r_nm);
      quad_in.corner[CORNER_TL].y = st7_ff.pos_y + $signed(st7_ff.r_np);
      quad_in.corner[CORNER_TR].x = st7_ff.pos_x + $signed(st7_ff.r_p);
      quad_in.corner[CORNER_TR].y = st7_ff.pos_y + $signed(st7_ff.r_nm);
      quad_in.corner[CORNER_BL].x = st7_ff.pos_x + $signed(st7_ff.r_np);
      quad_in.corner[CORNER_BL].y = st7_ff.pos_y + $signed(st7_ff.r_m);
      quad_in.corner[CORNER_BR].x = st7_ff.pos_x + $signed(st7_ff.r_m);
      quad_in.corner[CORNER_BR].y = st7_ff.pos_y + $signed(st7_ff.r_p);
      quad_in.color    = st7_ff.color;
      quad_in.progress = st7_ff.prog;
      quad_in.seed     = st7_ff.seed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         st5_ff  <= st5_in;
         st6_ff  <= st6_in;
         st7_ff  <= st7_in;
         quad_ff <= quad_in;
      end
   end

   qexp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .quad_valid (vld_ff[7]),
      .quad       (quad_ff),
      .quad_take  (quad_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_quad_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] && !adv |=> vld_ff[7] && $stable(quad_ff))
      else $error("quad in the last stage changed while its vertices were pending");

   a_dead_dropped: assert property (@(posedge clock) disable iff (reset)
      req_valid && adv && (req_data.life_left == 16'd0) |=> !vld_ff[0])
      else $error("dead particle entered the pipeline");

   a_stall_keeps: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] && !adv |=> vld_ff[6])
      else $error("particle lost from the pipeline during a stall");

endmodule

FILE: dv/particle_quad_expander_core_test.sv
module particle_quad_expander_core_test;
   import qexp_pkg::*;

   // Quiet margin after the last owed vertex, before a key write or the end.
   localparam int SETTLE_CYCLES = 30;
   localparam int ANGLE_W = 12;
   localparam int NUM_RANDOM = 450;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write_en;
   logic [15:0] csr_write_data;

   particle_quad_expander_core #(.ANGLE_BITS(ANGLE_W)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Our own copy of the draw key, kept in step with every register write.
   logic [15:0] key_shadow;

   // Vertices still owed by the block, oldest first.
   rsp_type vertex_queue[$];

   int error_count;
   int particles_sent;
   int quads_drawn;
   int vertices_seen;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #30000000;
      $display("Timeout with %0d vertices still owed.", vertex_queue.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Quarter-wave sine polynomial, z and the result in Q15.
   function automatic longint quarter_wave(input longint z);
      longint z2;
      longint r;
      z2 = (z * z) >>> 15;
      r = (2320 * z2) >>> 15;
      r = 21024 - r;
      r = (r * z2) >>> 15;
      r = 51472 - r;
      return (r * z) >>> 15;
   endfunction

   function automatic longint sine_of_phase(input logic [15:0] phase);
      longint z;
      longint v;
      z = longint'(phase[13:0]) << 1;
      v = phase[14] ? quarter_wave(32768 - z) : quarter_wave(z);
      return phase[15] ? -v : v;
   endfunction

   // Divide by 32768, rounding to nearest with halves going up.
   function automatic longint round_q15(input longint v);
      longint t;
      t = v + 16384;
      if (t >= 0) begin
         return t >>> 15;
      end
      return -(((-t) + 32767) >>> 15);
   endfunction

   function automatic longint mix(input longint fin, input longint beg, input longint w);
      return (fin * (65536 - w) + beg * w) >>> 16;
   endfunction

   // Works out the six vertices of one particle, or nothing when it is
   // dead or keyed to another pipeline.
   function automatic void expand_particle(input req_type p);
      longint prog, w, size, h, c, s, hc, hs, px, py, dx, dy, sx, sy;
      logic [31:0] color;
      logic [15:0] phase;
      logic [23:0] vx, vy;
      rsp_type v;
      int k;
      if (p.life_left == 0 || p.pipe_key != key_shadow) begin
         return;
      end
      if (p.life_left >= p.life_total) begin
         prog = 65535;
      end else begin
         prog = (longint'(p.life_left) << 16) / longint'(p.life_total);
      end
      w = prog + (prog >> 15);
      for (int ch = 0; ch < 4; ch++) begin
         color[ch*8 +: 8] = 8'(mix(p.color_final[ch*8 +: 8], p.color_begin[ch*8 +: 8], w));
      end
      size = mix(p.size_final, p.size_begin, w);
      h = size * 8;
      phase = 16'(p.angle[ANGLE_W-1:0]) << (16 - ANGLE_W);
      s = sine_of_phase(phase);
      c = sine_of_phase(phase + 16'd16384);
      hc = h * c;
      hs = h * s;
      px = longint'(p.pos_x);
      py = longint'(p.pos_y);
      for (k = 0; k < 6; k++) begin
         // Corner signs in the order tl, tr, bl, tr, br, bl.
         sx = (k == 1 || k == 3 || k == 4) ? 1 : -1;
         sy = (k == 2 || k == 4 || k == 5) ? 1 : -1;
         dx = round_q15(sx * hc - sy * hs);
         dy = round_q15(sx * hs + sy * hc);
         vx = 24'(px + dx);
         vy = 24'(py + dy);
         v.vert_x = vx;
         v.vert_y = vy;
         v.tex_u = (sx > 0);
         v.tex_v = (sy > 0);
         v.vert_color = color;
         v.progress = 16'(prog);
         v.seed_out = p.noise_seed;
         v.last = (k == 5);
         vertex_queue = {vertex_queue, v};
      end
      quads_drawn++;
   endfunction

   // Gap lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Response side: random back-pressure and in-order checking.
   int stall_left;
   bit calm_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            vertices_seen++;
            if (vertex_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Unexpected vertex transfer: %p", rsp_data);
               end
            end else if (rsp_data !== vertex_queue[0]) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Vertex mismatch: expected %p got %p", vertex_queue[0], rsp_data);
               end
               void'(vertex_queue.pop_front());
            end else begin
               void'(vertex_queue.pop_front());
            end
         end
         if (calm_phase) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(3) == 0) begin
               stall_left <= pick_gap();
            end
         end
      end
   end

   // Sends one particle; the prediction is taken when the transfer happens.
   // Valid is only dropped when a gap follows, so back-to-back transfers
   // keep it high.
   task automatic send_particle(input req_type p);
      int gap;
      gap = calm_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expand_particle(p);
      particles_sent++;
   endtask

   // Waits for every owed vertex, then lets the pipeline drain.
   task automatic drain();
      req_valid <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [15:0] k);
      csr_write_en <= 1'b1;
      csr_write_data <= k;
      @(posedge clock);
      csr_write_en <= 1'b0;
      key_shadow = k;
      @(posedge clock);
   endtask

   // A random particle; most are alive and on the drawn key.
   function automatic req_type random_particle();
      req_type p;
      logic [255:0] raw;
      int mode;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      p = raw[$bits(req_type)-1:0];
      mode = $urandom_range(99);
      if (mode < 85) begin
         p.pipe_key = key_shadow;
      end else if (mode < 90) begin
         p.pipe_key = key_shadow ^ 16'(1 << $urandom_range(15));
      end
      if ($urandom_range(19) == 0) begin
         p.life_left = 0;
      end
      if ($urandom_range(7) == 0) begin
         p.life_left = p.life_total + 16'($urandom_range(3));
      end
      if ($urandom_range(3) == 0) begin
         // Small values keep the corners near the center for readable failures.
         p.size_begin = 16'($urandom_range(0, 255));
         p.size_final = 16'($urandom_range(0, 255));
      end
      return p;
   endfunction

   // Directed table: each row a particle; a typed-in vertex is compared with
   // the predictor's first vertex as a sanity check on the predictor itself.
   typedef struct {
      req_type p;
      bit      has_typed;
      rsp_type typed;
   } directed_row_type;

   directed_row_type rows[$];

   function automatic req_type base_particle();
      req_type p;
      p = '0;
      p.life_left = 16'h0100;
      p.life_total = 16'h0100;
      return p;
   endfunction

   task automatic build_rows();
      directed_row_type r;
      req_type p;
      // Zero size, full life: every vertex sits on the center.
      p = base_particle();
      p.color_begin = 32'hFFFFFFFF;
      p.noise_seed = 16'hFFFF;
      r.p = p; r.has_typed = 1;
      r.typed = '{vert_x: 0, vert_y: 0, tex_u: 0, tex_v: 0, vert_color: 32'hFFFFFFFF,
                  progress: 16'hFFFF, seed_out: 16'hFFFF, last: 0};
      rows = {rows, r};
      // Dead particle.
      p = base_particle(); p.life_left = 0;
      r.p = p; r.has_typed = 0; rows = {rows, r};
      // Other key.
      p = base_particle(); p.pipe_key = 16'h0001;
      r.p = p; rows = {rows, r};
      // Zero life_total and life above total both saturate progress.
      p = base_particle(); p.life_total = 0; p.size_begin = 16'hFFFF;
      r.p = p; rows = {rows, r};
      p = base_particle(); p.life_left = 16'hFFFF; p.life_total = 16'h0001;
      r.p = p; rows = {rows, r};
      // Smallest nonzero life against the largest total.
      p = base_particle(); p.life_left = 1; p.life_total = 16'hFFFF;
      p.color_final = 32'hFFFFFFFF; p.size_final = 16'hFFFF;
      r.p = p; rows = {rows, r};
      // Position extremes with the largest quads, wrapping at 24 bits.
      p = base_particle(); p.pos_x = 24'h7FFFFF; p.pos_y = 24'h800000;
      p.size_begin = 16'hFFFF;
      r.p = p; rows = {rows, r};
      p = base_particle(); p.pos_x = 24'h800000; p.pos_y = 24'h7FFFFF;
      p.size_begin = 16'hFFFF; p.angle = 12'hFFF;
      r.p = p; rows = {rows, r};
      // Quadrant boundaries and the odd angles between them.
      for (int a = 0; a < 8; a++) begin
         p = base_particle(); p.size_begin = 16'h0100;
         p.angle = 12'(a * 512 + (a & 1));
         r.p = p; rows = {rows, r};
      end
      // Half life blends the two colors halfway.
      p = base_particle(); p.life_left = 16'h0080;
      p.color_begin = 32'hFF00FF00; p.color_final = 32'h00FF00FF;
      p.size_begin = 16'h0010; p.size_final = 16'h0030; p.angle = 12'd341;
      r.p = p; rows = {rows, r};
   endtask

   initial begin
      req_type p;
      rsp_type first;
      error_count = 0;
      particles_sent = 0;
      quads_drawn = 0;
      vertices_seen = 0;
      calm_phase = 0;
      key_shadow = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs with the reset key of zero.
      build_rows();
      foreach (rows[i]) begin
         if (rows[i].has_typed) begin
            expand_particle(rows[i].p);
            first = vertex_queue[$ - 5];
            repeat (6) void'(vertex_queue.pop_back());
            quads_drawn--;
            if (first !== rows[i].typed) begin
               error_count++;
               $display("Predictor disagrees with row %0d: %p", i, first);
            end
         end
         send_particle(rows[i].p);
      end
      drain();

      // Random part across several keys, extremes included.
      for (int phase_num = 0; phase_num < 5; phase_num++) begin
         case (phase_num)
            0: write_key(16'hFFFF);
            1: write_key(16'h0000);
            2: write_key(16'($urandom));
            3: write_key(16'h8001);
            default: write_key(16'($urandom));
         endcase
         // One phase runs without any idling on either side.
         calm_phase = (phase_num == 2);
         for (int n = 0; n < NUM_RANDOM / 5; n++) begin
            p = random_particle();
            send_particle(p);
         end
         drain();
      end
      calm_phase = 0;

      $display("Sent %0d particles; %0d drew quads, %0d vertices checked.",
               particles_sent, quads_drawn, vertices_seen);
      $display("Covered dead and foreign-key particles, saturated progress and five keys.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
